>>> hdl/legendre_binning_accumulator_core_macros.svh
// Assertion shorthands used by the checker of this block.
`ifndef LEGENDRE_BINNING_ACCUMULATOR_CORE_MACROS_SVH
`define LEGENDRE_BINNING_ACCUMULATOR_CORE_MACROS_SVH

// Checked only while out of reset.
`define LBA_ASSERT_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define LBA_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/lba_pkg.sv
package lba_pkg;
	localparam int MAX_COEFFS_DEF   = 64;
	localparam int NUM_ORBITALS_DEF = 4;

	localparam int MODE_W   = 2;
	localparam int TAU_W    = 24;
	localparam int WEIGHT_W = 32;
	localparam int ORB_W    = 2;
	localparam int COEFF_W  = 6;
	localparam int BETA_W   = 25;
	localparam int NCOEF_W  = 7;
	localparam int ACC_W    = 56;
	localparam int POLY_W   = 34;
	localparam int X_W      = 32;
	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 56;

	// queue entry without the address: mode, dt, neg, weight, ok
	localparam int ITEM_FIXED_W = MODE_W + BETA_W + 1 + WEIGHT_W + 1;

	localparam logic [BETA_W-1:0]  BETA_RESET  = 25'd16777216;
	localparam logic [NCOEF_W-1:0] NCOEF_RESET = 7'd30;

	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COMMIT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

	localparam logic REG_BETA  = 1'b0;
	localparam logic REG_NCOEF = 1'b1;
endpackage

>>> hdl/lba_divider.sv
module lba_divider #(
	parameter int DW = 56,
	parameter int VW = 25,
	parameter int P  = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int STEPS = (DW + P - 1) / P;
	localparam int DWP   = STEPS * P;
	localparam int CW    = $clog2(STEPS + 1);

	logic [VW-1:0]  rem_q, rem_d;
	logic [DWP-1:0] quo_q, quo_d;
	logic [VW-1:0]  div_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q, done_q;
	logic [VW:0]    trial;

	// P restoring steps per cycle
	always_comb begin
		rem_d = rem_q;
		quo_d = quo_q;
		trial = '0;
		for (int i = 0; i < P; i++) begin
			trial = {rem_d, quo_d[DWP-1]};
			quo_d = {quo_d[DWP-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_d    = VW'(trial - {1'b0, div_q});
				quo_d[0] = 1'b1;
			end else begin
				rem_d = VW'(trial);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			div_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= DWP'(dividend);
				div_q  <= divisor;
				cnt_q  <= CW'(STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= rem_d;
				quo_q <= quo_d;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[DW-1:0];
endmodule

>>> hdl/lba_queue.sv
module lba_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic         full,
	output logic         valid,
	output logic [W-1:0] head
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	assign full  = (cnt_q == CW'(DEPTH));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rp_q];
endmodule

>>> hdl/lba_front.sv
module lba_front #(
	parameter int MAX_COEFFS   = lba_pkg::MAX_COEFFS_DEF,
	parameter int NUM_ORBITALS = lba_pkg::NUM_ORBITALS_DEF,
	parameter int AW           = 10,
	parameter int ITEM_W       = lba_pkg::ITEM_FIXED_W + AW
) (
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [lba_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [lba_pkg::MODE_W-1:0]  s_tuser,
	input  logic [lba_pkg::BETA_W-1:0]  beta_eff,
	input  logic                        clearing,
	input  logic                        q_full,
	output logic                        push,
	output logic [ITEM_W-1:0]           item
);
	logic [lba_pkg::TAU_W-1:0]    tau_a, tau_c;
	logic [lba_pkg::WEIGHT_W-1:0] weight;
	logic                         sign_neg;
	logic [lba_pkg::ORB_W-1:0]    row, col;
	logic [lba_pkg::COEFF_W-1:0]  coeff;
	logic signed [25:0]           diff;
	logic signed [26:0]           wrapped;
	logic [lba_pkg::BETA_W-1:0]   dt;
	logic                         neg, orb_ok, coeff_ok, ok, keep;
	logic [31:0]                  base32;
	logic [AW-1:0]                addr;

	assign tau_a    = s_tdata[23:0];
	assign tau_c    = s_tdata[47:24];
	assign weight   = s_tdata[79:48];
	assign sign_neg = s_tdata[80];
	assign row      = s_tdata[82:81];
	assign col      = s_tdata[84:83];
	assign coeff    = s_tdata[90:85];

	// wrap the difference into the interval, flipping the sign, then clamp
	always_comb begin
		diff    = $signed({2'b00, tau_a}) - $signed({2'b00, tau_c});
		wrapped = {diff[25], diff};
		neg     = sign_neg;
		if (diff[25]) begin
			wrapped = {diff[25], diff} + $signed({2'b00, beta_eff});
			neg     = !sign_neg;
		end
		if (wrapped[26]) begin
			dt = '0;
		end else if (wrapped > $signed({2'b00, beta_eff})) begin
			dt = beta_eff;
		end else begin
			dt = wrapped[24:0];
		end
	end

	always_comb begin
		orb_ok   = (32'(row) < NUM_ORBITALS) && (32'(col) < NUM_ORBITALS);
		coeff_ok = 32'(coeff) < MAX_COEFFS;
		base32   = (32'(row) * NUM_ORBITALS + 32'(col)) * MAX_COEFFS;
		addr     = AW'(base32);
		ok       = 1'b1;
		keep     = 1'b0;
		unique case (s_tuser)
			lba_pkg::MODE_ADD: begin
				keep = orb_ok;
			end
			lba_pkg::MODE_COMMIT: begin
				keep = 1'b1;
			end
			lba_pkg::MODE_READ: begin
				keep = 1'b1;
				ok   = orb_ok && coeff_ok;
				addr = AW'(base32 + 32'(coeff));
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign s_tready = !q_full && !clearing;
	assign push     = s_tvalid && s_tready && keep;
	assign item     = {s_tuser, dt, neg, weight, addr, ok};
endmodule

>>> hdl/lba_back.sv
module lba_back #(
	parameter int MAX_COEFFS   = lba_pkg::MAX_COEFFS_DEF,
	parameter int NUM_ORBITALS = lba_pkg::NUM_ORBITALS_DEF,
	parameter int AW           = 10,
	parameter int ITEM_W       = lba_pkg::ITEM_FIXED_W + AW
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  logic [ITEM_W-1:0]            q_head,
	output logic                         q_pop,
	input  logic [lba_pkg::BETA_W-1:0]   beta_eff,
	input  logic [lba_pkg::NCOEF_W-1:0]  num_coeffs,
	output logic                         clearing,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [lba_pkg::OUT_DATA_W-1:0] m_tdata
);
	localparam int DEPTH = NUM_ORBITALS * NUM_ORBITALS * MAX_COEFFS;
	localparam int NW    = $clog2(MAX_COEFFS + 1);
	localparam int NUMW  = 37 + NW;
	localparam int DW    = NUMW - 1;
	localparam int XDW   = lba_pkg::BETA_W + 31;
	localparam int ACC_W = lba_pkg::ACC_W;
	localparam int PW    = lba_pkg::POLY_W;
	localparam logic signed [PW-1:0] ONE_Q30  = PW'(64'sd1073741824);
	localparam logic signed [PW-1:0] POLY_MAX = {1'b0, {(PW-1){1'b1}}};
	localparam logic signed [PW-1:0] POLY_MIN = {1'b1, {(PW-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_XDIV, ST_MUL, ST_RND, ST_ACC, ST_DSTART, ST_RDIV,
		ST_COMMIT, ST_READ, ST_RDATA
	} state_t;

	function automatic logic [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
		if (v[ACC_W] != v[ACC_W-1]) begin
			sat_acc = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			sat_acc = v[ACC_W-1:0];
		end
	endfunction

	// queue head fields
	logic [lba_pkg::MODE_W-1:0]   h_mode;
	logic [lba_pkg::BETA_W-1:0]   h_dt;
	logic                         h_neg;
	logic [lba_pkg::WEIGHT_W-1:0] h_w;
	logic [AW-1:0]                h_addr;
	logic                         h_ok;

	state_t                       state_q;
	logic [AW:0]                  cnt_q;
	logic                         have_s1;
	logic [AW-1:0]                addr_s1;
	logic signed [31:0]           w_q;
	logic                         neg_q, ok_q;
	logic [AW-1:0]                base_q, rd_addr_q;
	logic [NW-1:0]                nc_q, n_q, nc_eff;
	logic signed [lba_pkg::X_W-1:0] x_q;
	logic signed [PW-1:0]         cur_q, prev_q, next_p;
	logic [63:0]                  prod_t_q;
	logic signed [63:0]           prod_x_q;
	logic [39:0]                  term_q;
	logic                         tneg_q;
	logic signed [PW:0]           xp_q;
	logic signed [NUMW-1:0]       num_q, num_d;
	logic                         out_valid_q;
	logic [ACC_W-1:0]             out_data_q;

	logic [ACC_W-1:0] pmem [DEPTH];
	logic [ACC_W-1:0] tmem [DEPTH];
	logic             p_we, p_re, t_we, t_re;
	logic [AW-1:0]    p_waddr, p_raddr, t_waddr, t_raddr;
	logic [ACC_W-1:0] p_wdata, t_wdata, p_rdata, t_rdata;

	logic             xdiv_start, xdiv_done, rdiv_start, rdiv_done;
	logic [XDW-1:0]   xquo;
	logic [DW-1:0]    rquo;
	logic [DW-1:0]    num_mag;
	logic [31:0]      wmag;
	logic [PW-1:0]    cmag;
	logic [63:0]      pmag;
	logic [PW-1:0]    xpm;
	logic [39:0]      term_d;
	logic signed [ACC_W:0] acc_sum;
	logic signed [NUMW-1:0] k_odd, k_n;

	assign {h_mode, h_dt, h_neg, h_w, h_addr, h_ok} = q_head;

	assign nc_eff = (32'(num_coeffs) > MAX_COEFFS) ? NW'(MAX_COEFFS) : NW'(num_coeffs);
	assign q_pop  = (state_q == ST_IDLE) && q_valid;
	assign xdiv_start = q_pop && (h_mode == lba_pkg::MODE_ADD) && (nc_eff != '0);
	assign rdiv_start = (state_q == ST_DSTART);
	assign num_mag    = num_q[NUMW-1] ? DW'(-num_q) : DW'(num_q);

	lba_divider #(.DW(XDW), .VW(lba_pkg::BETA_W), .P(4)) u_xdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (xdiv_start),
		.dividend ({h_dt, 31'b0}),
		.divisor  (beta_eff),
		.done     (xdiv_done),
		.quotient (xquo)
	);

	lba_divider #(.DW(DW), .VW(NW), .P(6)) u_rdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rdiv_start),
		.dividend (num_mag),
		.divisor  (n_q + NW'(1)),
		.done     (rdiv_done),
		.quotient (rquo)
	);

	// datapath pieces of the per-order loop
	always_comb begin
		wmag   = w_q[31] ? 32'(-w_q) : 32'(w_q);
		cmag   = cur_q[PW-1] ? PW'(-cur_q) : PW'(cur_q);
		// 64-bit wraparound of the rounding add is intended
		term_d = 40'((prod_t_q + 64'd8388608) >> 24);
		pmag   = prod_x_q[63] ? (64'd0 - prod_x_q) : prod_x_q;
		xpm    = PW'((pmag + 64'd536870912) >> 30);
		acc_sum = $signed({p_rdata[ACC_W-1], p_rdata})
			+ (tneg_q ? -$signed({17'd0, term_q}) : $signed({17'd0, term_q}));
		k_odd  = NUMW'($signed({1'b0, n_q, 1'b1}));
		k_n    = NUMW'($signed({1'b0, n_q}));
		num_d  = k_odd * NUMW'(xp_q) - k_n * NUMW'(prev_q);
		if (num_q[NUMW-1]) begin
			next_p = (rquo > DW'(64'd8589934592)) ? POLY_MIN : -$signed(PW'(rquo));
		end else begin
			next_p = (rquo > DW'(64'd8589934591)) ? POLY_MAX : $signed(PW'(rquo));
		end
	end

	// memory port control
	always_comb begin
		p_we    = 1'b0;
		p_waddr = addr_s1;
		p_wdata = '0;
		p_re    = 1'b0;
		p_raddr = cnt_q[AW-1:0];
		t_we    = 1'b0;
		t_waddr = addr_s1;
		t_wdata = sat_acc($signed({t_rdata[ACC_W-1], t_rdata})
			+ $signed({p_rdata[ACC_W-1], p_rdata}));
		t_re    = 1'b0;
		t_raddr = cnt_q[AW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				p_we    = 1'b1;
				p_waddr = cnt_q[AW-1:0];
				t_we    = 1'b1;
				t_waddr = cnt_q[AW-1:0];
				t_wdata = '0;
			end
			ST_MUL: begin
				p_re    = 1'b1;
				p_raddr = AW'(32'(base_q) + 32'(n_q));
			end
			ST_ACC: begin
				p_we    = 1'b1;
				p_waddr = AW'(32'(base_q) + 32'(n_q));
				p_wdata = sat_acc(acc_sum);
			end
			ST_COMMIT: begin
				p_we = have_s1;
				t_we = have_s1;
				p_re = (cnt_q != (AW + 1)'(DEPTH));
				t_re = p_re;
			end
			ST_READ: begin
				t_re    = !out_valid_q && ok_q;
				t_raddr = rd_addr_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (p_we) begin
			pmem[p_waddr] <= p_wdata;
		end
		if (p_re) begin
			p_rdata <= pmem[p_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			tmem[t_waddr] <= t_wdata;
		end
		if (t_re) begin
			t_rdata <= tmem[t_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			have_s1     <= 1'b0;
			addr_s1     <= '0;
			w_q         <= '0;
			neg_q       <= 1'b0;
			ok_q        <= 1'b0;
			base_q      <= '0;
			rd_addr_q   <= '0;
			nc_q        <= '0;
			n_q         <= '0;
			x_q         <= '0;
			cur_q       <= '0;
			prev_q      <= '0;
			prod_t_q    <= '0;
			prod_x_q    <= '0;
			term_q      <= '0;
			tneg_q      <= 1'b0;
			xp_q        <= '0;
			num_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (AW + 1)'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						w_q       <= $signed(h_w);
						neg_q     <= h_neg;
						base_q    <= h_addr;
						nc_q      <= nc_eff;
						rd_addr_q <= h_addr;
						ok_q      <= h_ok;
						cnt_q     <= '0;
						have_s1   <= 1'b0;
						priority case (h_mode)
							lba_pkg::MODE_ADD:    state_q <= (nc_eff != '0) ? ST_XDIV : ST_IDLE;
							lba_pkg::MODE_COMMIT: state_q <= ST_COMMIT;
							lba_pkg::MODE_READ:   state_q <= ST_READ;
							default:              state_q <= ST_IDLE;
						endcase
					end
				end
				ST_XDIV: begin
					if (xdiv_done) begin
						x_q    <= lba_pkg::X_W'($signed({1'b0, xquo[31:0]}) - 33'sd1073741824);
						cur_q  <= ONE_Q30;
						prev_q <= '0;
						n_q    <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_t_q <= 64'(wmag * {30'd0, cmag});
					prod_x_q <= 64'(66'(x_q) * 66'(cur_q));
					tneg_q   <= neg_q ^ (w_q[31] ^ cur_q[PW-1]);
					state_q  <= ST_RND;
				end
				ST_RND: begin
					term_q  <= term_d;
					xp_q    <= prod_x_q[63] ? -$signed({1'b0, xpm}) : $signed({1'b0, xpm});
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					num_q <= num_d;
					if ((n_q + NW'(1)) == nc_q) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DSTART;
					end
				end
				ST_DSTART: begin
					state_q <= ST_RDIV;
				end
				ST_RDIV: begin
					if (rdiv_done) begin
						prev_q  <= cur_q;
						cur_q   <= next_p;
						n_q     <= n_q + NW'(1);
						state_q <= ST_MUL;
					end
				end
				ST_COMMIT: begin
					// read at cnt, write back in the next cycle at addr_s1
					if (cnt_q != (AW + 1)'(DEPTH)) begin
						addr_s1 <= cnt_q[AW-1:0];
						have_s1 <= 1'b1;
						cnt_q   <= cnt_q + 1'b1;
					end else begin
						have_s1 <= 1'b0;
						if (!have_s1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_READ: begin
					if (!out_valid_q) begin
						if (ok_q) begin
							state_q <= ST_RDATA;
						end else begin
							out_valid_q <= 1'b1;
							out_data_q  <= '0;
							state_q     <= ST_IDLE;
						end
					end
				end
				ST_RDATA: begin
					out_valid_q <= 1'b1;
					out_data_q  <= t_rdata;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign clearing = (state_q == ST_CLEAR);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
endmodule

>>> hdl/legendre_binning_accumulator_core.sv
// Legendre accumulator for imaginary-time operator pairs. An add-pair item
// (tuser 0) runs the x = 2*dt/beta - 1 divider, then for each Legendre
// order a multiply, a round, a read-modify-write of the partial table and,
// but for the last order, a divide by n+1 in the recurrence. A commit
// (tuser 1) sweeps both tables of NUM_ORBITALS^2*MAX_COEFFS entries (1024
// by default). A read (tuser 2) returns one 56-bit Q26.30 total. After
// reset both tables are cleared in a pass during which s_tready stays low.
// A two-entry queue lets new items be taken while the back end is busy;
// the user must write configuration only when idle, which the block itself
// does not enforce.
module legendre_binning_accumulator_core #(
	parameter int MAX_COEFFS   = lba_pkg::MAX_COEFFS_DEF,
	parameter int NUM_ORBITALS = lba_pkg::NUM_ORBITALS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [lba_pkg::BETA_W-1:0]     cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// tau_annihilate[23:0], tau_create[47:24], weight[79:48],
	// sign_negative[80], orbital_row[82:81], orbital_col[84:83],
	// coeff_index[90:85], zero fill
	input  logic [lba_pkg::IN_DATA_W-1:0]  s_tdata,
	// mode
	input  logic [lba_pkg::MODE_W-1:0]     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// total_value[55:0]
	output logic [lba_pkg::OUT_DATA_W-1:0] m_tdata
);
	localparam int DEPTH  = NUM_ORBITALS * NUM_ORBITALS * MAX_COEFFS;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ITEM_W = lba_pkg::ITEM_FIXED_W + AW;

	logic [lba_pkg::BETA_W-1:0]  beta_q, beta_eff;
	logic [lba_pkg::NCOEF_W-1:0] ncoef_q;
	logic                        clearing, q_full, q_valid, push, pop;
	logic [ITEM_W-1:0]           item, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q  <= lba_pkg::BETA_RESET;
			ncoef_q <= lba_pkg::NCOEF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lba_pkg::REG_BETA:  beta_q  <= cfg_wdata;
				lba_pkg::REG_NCOEF: ncoef_q <= cfg_wdata[lba_pkg::NCOEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// zero beta behaves as one tick
	assign beta_eff = (beta_q == '0) ? lba_pkg::BETA_W'(1) : beta_q;

	lba_front #(
		.MAX_COEFFS  (MAX_COEFFS),
		.NUM_ORBITALS(NUM_ORBITALS),
		.AW          (AW),
		.ITEM_W      (ITEM_W)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.beta_eff (beta_eff),
		.clearing (clearing),
		.q_full   (q_full),
		.push     (push),
		.item     (item)
	);

	lba_queue #(.W(ITEM_W), .DEPTH(2)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (item),
		.pop       (pop),
		.full      (q_full),
		.valid     (q_valid),
		.head      (head)
	);

	lba_back #(
		.MAX_COEFFS  (MAX_COEFFS),
		.NUM_ORBITALS(NUM_ORBITALS),
		.AW          (AW),
		.ITEM_W      (ITEM_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_head     (head),
		.q_pop      (pop),
		.beta_eff   (beta_eff),
		.num_coeffs (ncoef_q),
		.clearing   (clearing),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);
endmodule

>>> hdl/lba_checker.sv
`include "legendre_binning_accumulator_core_macros.svh"

module lba_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [lba_pkg::OUT_DATA_W-1:0] m_tdata
);
	// a held result keeps its data until the transfer
	`LBA_ASSERT_RST(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

	// nothing is taken or offered while in reset
	`LBA_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !s_tready && !m_tvalid, "handshake active during reset")

	// the clearing pass holds off input right after reset
	`LBA_ASSERT_ALWAYS(a_clear_first, clk, $rose(arst_n) |-> !s_tready, "input taken before table clear")
endmodule

bind legendre_binning_accumulator_core lba_checker u_lba_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
